// ===== rtl/bia_pkg.sv =====
`default_nettype none

package bia_pkg;

  localparam int IdCapacity = 1024;
  localparam int WordBits   = 32;
  localparam int NumWords   = (IdCapacity + WordBits - 1) / WordBits;
  localparam int WordIdxW   = $clog2(NumWords);
  localparam int BitIdxW    = $clog2(WordBits);
  localparam int IdW        = 10;
  localparam int CntW       = 11;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWrite,
    StDone
  } state_e;

  typedef enum logic [1:0] {
    StatAlloc      = 2'd0,
    StatNoSpace    = 2'd1,
    StatReleased   = 2'd2,
    StatBadRelease = 2'd3
  } status_e;

  typedef enum logic {
    OpAlloc   = 1'b0,
    OpRelease = 1'b1
  } op_e;

  // Result of the free-bit search over one bitmap word.
  typedef struct packed {
    logic               found;
    logic [BitIdxW-1:0] idx;
  } ffz_t;

endpackage

`default_nettype wire

// ===== rtl/bia_ffz.sv =====
`default_nettype none

module bia_ffz (
  input  logic [bia_pkg::WordBits-1:0] word_i,
  input  logic                         last_i,
  input  logic [bia_pkg::BitIdxW-1:0]  last_bit_i,
  output bia_pkg::ffz_t                res_o
);
  import bia_pkg::*;

  logic [WordBits-1:0] usable;
  logic [WordBits-1:0] free;

  // In the last word only the bits below the limit may be handed out.
  always_comb begin
    if (last_i) begin
      usable = {WordBits{1'b1}} >> (BitIdxW'(WordBits - 1) - last_bit_i);
    end else begin
      usable = {WordBits{1'b1}};
    end
    free = ~word_i & usable;
  end

  always_comb begin
    res_o.found = 1'b0;
    res_o.idx   = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (free[i]) begin
        res_o.found = 1'b1;
        res_o.idx   = BitIdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bitmap_id_allocator.sv =====
// Channel   Handshake                     Payload
// request   start, busy (accept: start&!busy) op_i, release_id_i
// result    done_o (one-cycle strobe)     given_id_o, status_o, used_count_o
// config    cfg_valid_i, cfg_ready_o      cfg_id_limit_i
//
// An allocate scans the bitmap one 32-bit word per cycle through one free-bit search
// unit: a hit in one of the 32 words goes through the write state to done_o, and a
// search that finds nothing goes straight to done_o at the word of the limit.
// With a zero limit done_o is high in the cycle right after the accepting edge.
// A release goes from scan through write to the strobe, or skips write for a free id.
// The bitmap is cleared at once by reset through per-word valid flags.
// Results cannot be stalled; busy falls after the strobe, so requests never overlap.
`default_nettype none

module bitmap_id_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       op_i,
  input  logic [bia_pkg::IdW-1:0]    release_id_i,
  output logic                       done_o,
  output logic [bia_pkg::IdW-1:0]    given_id_o,
  output logic [1:0]                 status_o,
  output logic [bia_pkg::CntW-1:0]   used_count_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bia_pkg::CntW-1:0]   cfg_id_limit_i
);
  import bia_pkg::*;

  state_e               state_q, state_d;
  logic [WordIdxW-1:0]  word_q, word_d;
  logic [BitIdxW-1:0]   bit_q, bit_d;
  op_e                  op_q, op_d;
  logic [IdW-1:0]       given_q, given_d;
  status_e              status_q, status_d;
  logic [CntW-1:0]      used_q, used_d;
  logic [WordBits-1:0]  wr_data_q, wr_data_d;
  logic [CntW-1:0]      id_limit_q;

  logic [WordBits-1:0]  mem [NumWords];
  logic [NumWords-1:0]  mem_vld_q;
  logic [WordBits-1:0]  rd_data_q;
  logic                 rd_vld_q;
  logic [WordBits-1:0]  word_data;

  logic [CntW-1:0]      lim_eff;
  logic [CntW-1:0]      lim_m1;
  logic                 lim_zero;
  logic [WordIdxW-1:0]  last_word;
  logic [BitIdxW-1:0]   last_bit;
  logic                 is_last;
  ffz_t                 ffz;

  always_comb begin
    lim_eff   = (id_limit_q > CntW'(IdCapacity)) ? CntW'(IdCapacity) : id_limit_q;
    lim_zero  = (lim_eff == '0);
    lim_m1    = lim_eff - CntW'(1);
    last_word = lim_m1[BitIdxW +: WordIdxW];
    last_bit  = lim_m1[BitIdxW-1:0];
    is_last   = (word_q == last_word);
    word_data = rd_vld_q ? rd_data_q : '0;
  end

  bia_ffz u_ffz (
    .word_i     (word_data),
    .last_i     (is_last),
    .last_bit_i (last_bit),
    .res_o      (ffz)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          if (op_e'(op_i) == OpAlloc && lim_zero) begin
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (op_q == OpAlloc) begin
          if (ffz.found) begin
            state_d = StWrite;
          end else if (is_last) begin
            state_d = StDone;
          end
        end else if (word_data[bit_q]) begin
          state_d = StWrite;
        end else begin
          state_d = StDone;
        end
      end
      StWrite: state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath next values.
  always_comb begin
    word_d    = word_q;
    bit_d     = bit_q;
    op_d      = op_q;
    given_d   = given_q;
    status_d  = status_q;
    used_d    = used_q;
    wr_data_d = wr_data_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          op_d     = op_e'(op_i);
          bit_d    = release_id_i[BitIdxW-1:0];
          given_d  = '0;
          status_d = StatNoSpace;
          if (op_e'(op_i) == OpRelease) begin
            word_d = release_id_i[BitIdxW +: WordIdxW];
          end else begin
            word_d = '0;
          end
        end
      end
      StScan: begin
        if (op_q == OpAlloc) begin
          if (ffz.found) begin
            given_d   = {word_q, ffz.idx};
            wr_data_d = word_data | (WordBits'(1) << ffz.idx);
            used_d    = used_q + CntW'(1);
            status_d  = StatAlloc;
          end else if (is_last) begin
            status_d = StatNoSpace;
          end else begin
            word_d = word_q + WordIdxW'(1);
          end
        end else if (word_data[bit_q]) begin
          // Every 10-bit identifier lies below the capacity, so only the mark decides.
          wr_data_d = word_data & ~(WordBits'(1) << bit_q);
          if (used_q != '0) begin
            used_d = used_q - CntW'(1);
          end
          status_d = StatReleased;
        end else begin
          status_d = StatBadRelease;
        end
      end
      StWrite: ;
      StDone:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      used_q     <= '0;
      id_limit_q <= CntW'(IdCapacity);
      mem_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      op_q       <= OpAlloc;
      status_q   <= StatAlloc;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      op_q     <= op_d;
      status_q <= status_d;
      rd_vld_q <= mem_vld_q[word_d];
      if (cfg_valid_i && cfg_ready_o) begin
        id_limit_q <= cfg_id_limit_i;
      end
      if (state_q == StWrite) begin
        mem_vld_q[word_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    bit_q     <= bit_d;
    given_q   <= given_d;
    wr_data_q <= wr_data_d;
  end

  // Bitmap storage: the read address follows the word the next cycle will examine.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[word_d];
    if (state_q == StWrite) begin
      mem[word_q] <= wr_data_q;
    end
  end

  // Outputs.
  always_comb begin
    busy         = (state_q != StIdle);
    done_o       = (state_q == StDone);
    given_id_o   = given_q;
    status_o     = status_q;
    used_count_o = used_q;
    cfg_ready_o  = 1'b1;
  end

endmodule

`default_nettype wire

// ===== rtl/bia_checker.sv =====
`default_nettype none

module bia_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     done_o,
  input logic [bia_pkg::IdW-1:0]  given_id_o,
  input logic [1:0]               status_o,
  input logic [bia_pkg::CntW-1:0] used_count_o
);
  import bia_pkg::*;

  // A taken request keeps the block busy until its result has gone out.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  a_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StatAlloc |-> given_id_o == '0)
    else $error("identifier given without allocation");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> used_count_o <= CntW'(IdCapacity))
    else $error("used count above capacity");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .given_id_o   (given_id_o),
  .status_o     (status_o),
  .used_count_o (used_count_o)
);

`default_nettype wire

// ===== bench/tb_bitmap_id_allocator.sv =====
`timescale 1ns / 100ps

module tb_bitmap_id_allocator;
  import bia_pkg::*;

  typedef struct {
    logic [IdW-1:0]  given_id;
    status_e         status;
    logic [CntW-1:0] used_count;
  } grant_t;

  class id_pool_board;
    bit          marked[IdCapacity];
    int          in_use;
    int          id_limit;
    grant_t      grant_queue[$];
    int          mismatches;
    int          status_seen[4];

    function new();
      foreach (marked[i]) marked[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      in_use     = 0;
      id_limit   = 1024;
      mismatches = 0;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 50) $display("%0t: mismatch: %s", $realtime, what);
    endtask

    // Works out the outcome of one accepted request and queues it.
    function void note_request(op_e op, logic [IdW-1:0] rid);
      grant_t g;
      int     lim;
      int     pick;
      bit     found;
      g.given_id = '0;
      found      = 1'b0;
      pick       = 0;
      if (op == OpAlloc) begin
        lim = (id_limit > IdCapacity) ? IdCapacity : id_limit;
        for (int k = 0; k < lim; k++) begin
          if (!found && !marked[k]) begin
            found = 1'b1;
            pick  = k;
          end
        end
        if (found) begin
          marked[pick] = 1'b1;
          in_use++;
          g.given_id = pick[IdW-1:0];
          g.status   = StatAlloc;
        end else begin
          g.status = StatNoSpace;
        end
      end else begin
        // A marked identifier can be released even above a lowered limit.
        if (marked[rid]) begin
          marked[rid] = 1'b0;
          if (in_use > 0) in_use--;
          g.status = StatReleased;
        end else begin
          g.status = StatBadRelease;
        end
      end
      g.used_count = in_use[CntW-1:0];
      grant_queue.push_back(g);
    endfunction

    task check_result(logic [IdW-1:0] gid, logic [1:0] st, logic [CntW-1:0] cnt);
      grant_t g;
      if (grant_queue.size() == 0) begin
        report($sformatf("result with nothing pending: id %0d status %0d count %0d",
                         gid, st, cnt));
        return;
      end
      g = grant_queue.pop_front();
      status_seen[g.status]++;
      if (gid !== g.given_id)
        report($sformatf("given_id %0d, expected %0d", gid, g.given_id));
      if (st !== g.status)
        report($sformatf("status %0d, expected %0d", st, g.status));
      if (cnt !== g.used_count)
        report($sformatf("used_count %0d, expected %0d", cnt, g.used_count));
    endtask

    // Returns some marked identifier, or -1 when the pool is empty.
    function int pick_marked();
      int base;
      int idx;
      base = $urandom_range(0, IdCapacity - 1);
      for (int k = 0; k < IdCapacity; k++) begin
        idx = (base + k) % IdCapacity;
        if (marked[idx]) return idx;
      end
      return -1;
    endfunction
  endclass

  localparam int QuietLimit = 2000;
  localparam int TotalItems = 1250;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                op_i           = 1'b0;
  logic [IdW-1:0]      release_id_i   = '0;
  logic                cfg_valid_i    = 1'b0;
  logic [CntW-1:0]     cfg_id_limit_i = '0;
  logic                busy;
  logic                done_o;
  logic [IdW-1:0]      given_id_o;
  logic [1:0]          status_o;
  logic [CntW-1:0]     used_count_o;
  logic                cfg_ready_o;

  id_pool_board board;
  int           sent_count  = 0;
  int           cfg_writes  = 0;
  int           quiet_cycles = 0;

  bitmap_id_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .release_id_i   (release_id_i),
    .done_o         (done_o),
    .given_id_o     (given_id_o),
    .status_o       (status_o),
    .used_count_o   (used_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_id_limit_i (cfg_id_limit_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) board.check_result(given_id_o, status_o, used_count_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1 ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("bitmap_id_allocator test failed");
      $finish;
    end
  end

  task automatic send_request(op_e op, logic [IdW-1:0] rid);
    start        <= 1'b1;
    op_i         <= op;
    release_id_i <= rid;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    board.note_request(op, rid);
    sent_count++;
  endtask

  task automatic pause_sender();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.grant_queue.size() != 0) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CntW-1:0] lim);
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_id_limit_i <= lim;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    board.id_limit = lim;
    cfg_writes++;
  endtask

  // Mostly small limits so the pool fills up often; zero and values past
  // the capacity show up too.
  function automatic logic [CntW-1:0] pick_limit();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 11'd1;
      2:       return 11'd1024;
      3:       return 11'd2047;
      4:       return 11'($urandom_range(1025, 2046));
      5, 6, 7: return 11'($urandom_range(2, 70));
      8, 9:    return 11'(32 * $urandom_range(1, 4) + $urandom_range(0, 2) - 1);
      default: return 11'($urandom_range(1, 1024));
    endcase
  endfunction

  initial begin
    op_e            op;
    logic [IdW-1:0] rid;
    int             mk;
    int             rand_count;
    int             alloc_pct;
    int             phase_len;
    bit             steady;

    board      = new();
    rand_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset limit.
    send_request(OpAlloc, 10'd1023);
    send_request(OpAlloc, 10'd0);
    send_request(OpAlloc, 10'd0);
    pause_sender();
    send_request(OpAlloc, 10'd0);
    send_request(OpRelease, 10'd1);
    send_request(OpRelease, 10'd1);
    send_request(OpRelease, 10'd1023);
    send_request(OpRelease, 10'd0);
    send_request(OpAlloc, 10'd0);
    send_request(OpAlloc, 10'd0);
    write_limit(11'd2);
    send_request(OpAlloc, 10'd0);
    send_request(OpRelease, 10'd3);
    send_request(OpRelease, 10'd2);
    write_limit(11'd0);
    send_request(OpAlloc, 10'd1023);
    send_request(OpRelease, 10'd0);
    write_limit(11'd2047);
    send_request(OpAlloc, 10'd0);
    send_request(OpAlloc, 10'd0);
    write_limit(11'd1);
    send_request(OpAlloc, 10'd0);
    send_request(OpRelease, 10'd1);
    send_request(OpAlloc, 10'd0);
    send_request(OpRelease, 10'd0);

    // Random phases, each under a fresh limit. The budget leaves room for the
    // requests that fill the pool at the end.
    while (sent_count + (IdCapacity - board.in_use) + 4 < TotalItems) begin
      write_limit(pick_limit());
      steady    = ($urandom_range(0, 3) == 0);
      alloc_pct = $urandom_range(25, 85);
      phase_len = $urandom_range(15, 90);
      repeat (phase_len) begin
        rid = $urandom_range(0, IdCapacity - 1);
        if ($urandom_range(0, 99) < alloc_pct) begin
          op = OpAlloc;
        end else begin
          op = OpRelease;
          if ($urandom_range(0, 99) < 85) begin
            mk = board.pick_marked();
            if (mk >= 0) rid = mk[IdW-1:0];
          end
        end
        send_request(op, rid);
        rand_count++;
        if (!steady) pause_sender();
      end
    end

    // Fill the whole pool, then work at the top of the range.
    write_limit(11'd1024);
    while (board.in_use < IdCapacity) begin
      rid = $urandom_range(0, IdCapacity - 1);
      send_request(OpAlloc, rid);
    end
    send_request(OpAlloc, 10'd0);
    send_request(OpRelease, 10'd1023);
    send_request(OpRelease, 10'd1023);
    send_request(OpAlloc, 10'd0);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (board.grant_queue.size() != 0)
      board.report($sformatf("%0d results never arrived", board.grant_queue.size()));

    $display("Ran %0d requests (%0d random) under %0d limit settings, ending with a full pool.",
             sent_count, rand_count, cfg_writes);
    $display("Outcomes: %0d granted, %0d no space, %0d released, %0d bad releases.",
             board.status_seen[StatAlloc], board.status_seen[StatNoSpace],
             board.status_seen[StatReleased], board.status_seen[StatBadRelease]);
    if (board.mismatches == 0) begin
      $display("bitmap_id_allocator test passed");
    end else begin
      $display("bitmap_id_allocator test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bia_pkg.sv
rtl/bia_ffz.sv
rtl/bitmap_id_allocator.sv
rtl/bia_checker.sv
bench/tb_bitmap_id_allocator.sv
